FILE: rtl/retransmit_message_queue_unit_defines.svh
// Assertion macros for the retransmit message queue unit.
`ifndef RETRANSMIT_MESSAGE_QUEUE_UNIT_DEFINES_SVH
`define RETRANSMIT_MESSAGE_QUEUE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, off during rst.
`define RMQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq assertion failed");
// Next-cycle implication, checked on clk, off during rst.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_IMP(label, ante, cons)
`define RMQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/rmq_pkg.sv
// Shared types and constants of the retransmit message queue unit.
`default_nettype none
package rmq_pkg;
  localparam int DEPTH_DEF      = 16;
  localparam int HANDLE_MAX_DEF = 32767;
  localparam int TIME_BITS_DEF  = 32;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 16;

  localparam logic [1:0] CMD_ENQ     = 2'd0;
  localparam logic [1:0] CMD_CONFIRM = 2'd1;
  localparam logic [1:0] CMD_TX      = 2'd2;
  localparam logic [1:0] CMD_DROP    = 2'd3;

  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_BUF_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TO   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_TO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETR = 8'd3;

  localparam logic [4:0]  CAPACITY_RST = 5'd16;
  localparam logic [15:0] ACK_TO_RST   = 16'd5;
  localparam logic [15:0] RETRY_TO_RST = 16'd1;
  localparam logic [7:0]  MAX_RETR_RST = 8'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_RD, S_EV, S_FIN, S_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/rmq_if.sv
// Channel interfaces: command input, result output, configuration write.
`default_nettype none
interface rmq_in_if #(parameter int TIME_BITS = rmq_pkg::TIME_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [TIME_BITS-1:0] now;
  logic [15:0]          packet_ref;
  logic [15:0]          handle_in;
  logic [1:0]           confirm_status;
  modport source (output valid, cmd, now, packet_ref, handle_in, confirm_status,
                  input ready);
  modport sink (input valid, cmd, now, packet_ref, handle_in, confirm_status,
                output ready);
endinterface

interface rmq_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] handle_out;
  logic [15:0] sent_packet;
  logic        removed_after_send;
  logic [4:0]  dropped_count;
  logic [4:0]  occupancy;
  logic        blocked;
  modport source (output valid, ok, handle_out, sent_packet, removed_after_send,
                  dropped_count, occupancy, blocked, input ready);
  modport sink (input valid, ok, handle_out, sent_packet, removed_after_send,
                dropped_count, occupancy, blocked, output ready);
endinterface

interface rmq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rmq_pkg::CFG_IDX_W-1:0]  index;
  logic [rmq_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/retransmit_message_queue_unit.sv
// Retransmit message queue: ordered table of packets awaiting acknowledgement.
// Enqueue and blocked transmit go from SETUP straight to DONE; confirm, transmit
// and drop scan the table entry by entry in RD and EV through the single RAM
// read port, then pass FIN before DONE. One item at a time: a new command beat is
// taken only after the result beat of the last one has been taken.
// Reset (synchronous rst) empties the table, clears counter and block, loads defaults.
`default_nettype none
`include "retransmit_message_queue_unit_defines.svh"
module retransmit_message_queue_unit #(
  parameter int QUEUE_DEPTH = rmq_pkg::DEPTH_DEF,
  parameter int HANDLE_MAX  = rmq_pkg::HANDLE_MAX_DEF,
  parameter int TIME_BITS   = rmq_pkg::TIME_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rmq_in_if.sink   in_ch,
  rmq_out_if.source out_ch,
  rmq_cfg_if.sink  cfg
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = TIME_BITS + 2;               // signed next-send width
  localparam int PW = 25;                          // (max_retries+1)*ack_timeout
  localparam int LW = ((TIME_BITS > PW) ? TIME_BITS : PW) + 2;
  localparam int EW = 16 + 16 + TIME_BITS + NW + 8;

  // Configuration registers; writes must come only while idle, which the block does not enforce.
  logic [4:0]  capacity;
  logic [15:0] ack_timeout;
  logic [15:0] retry_timeout;
  logic [7:0]  max_retries;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= rmq_pkg::CAPACITY_RST;
      ack_timeout   <= rmq_pkg::ACK_TO_RST;
      retry_timeout <= rmq_pkg::RETRY_TO_RST;
      max_retries   <= rmq_pkg::MAX_RETR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rmq_pkg::REG_CAPACITY: capacity      <= cfg.data[4:0];
        rmq_pkg::REG_ACK_TO:   ack_timeout   <= cfg.data;
        rmq_pkg::REG_RETRY_TO: retry_timeout <= cfg.data;
        rmq_pkg::REG_MAX_RETR: max_retries   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  rmq_pkg::state_t st, st_next;

  logic [1:0]           cmd_q;
  logic [TIME_BITS-1:0] now_q;
  logic [15:0]          pref_q;
  logic [15:0]          hin_q;
  logic [1:0]           status_q;
  logic [PW-1:0]        prod_q;
  logic signed [LW-1:0] limit_q;

  logic [CW-1:0] count;
  logic [15:0]   hcnt;
  logic          blk;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  logic          found;

  logic        res_ok;
  logic [15:0] res_hout;
  logic [15:0] res_sent;
  logic        res_rem;
  logic [4:0]  res_drop;

  // Table storage: one word per entry.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  rmq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturate a wide next-send sum into the signed NW range.
  function automatic logic [NW-1:0] clamp_ns(input logic signed [NW+1:0] v);
    logic signed [NW+1:0] hi;
    logic signed [NW+1:0] lo;
    hi = $signed({3'b000, {(NW-1){1'b1}}});
    lo = -hi - $signed((NW+2)'(1));
    if (v > hi) begin
      return hi[NW-1:0];
    end else if (v < lo) begin
      return lo[NW-1:0];
    end
    return v[NW-1:0];
  endfunction

  // Unpack the entry read in the previous cycle.
  logic [15:0]           d_pkt;
  logic [15:0]           d_hdl;
  logic [TIME_BITS-1:0]  d_first;
  logic signed [NW-1:0]  d_next;
  logic [7:0]            d_ret;
  assign {d_pkt, d_hdl, d_first, d_next, d_ret} = ram_rdata;

  logic [7:0]           bumped;
  logic                 tx_hit;
  logic                 tx_remove;
  logic                 cf_hit;
  logic                 resched;
  logic                 kill;
  logic [NW-1:0]        cf_next;
  logic [NW-1:0]        tx_next;
  logic [TIME_BITS-1:0] first_new;
  logic [CW-1:0]        rd_inc;
  logic                 last;
  logic                 can_enq;
  logic                 in_acc;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign bumped    = (d_ret == 8'hFF) ? d_ret : d_ret + 8'd1;
  assign tx_hit    = (d_pkt != 16'd0) && (d_next <= $signed({2'b00, now_q}));
  assign tx_remove = bumped >= max_retries;
  assign cf_hit    = d_hdl == hin_q;
  assign resched   = (d_pkt != 16'd0) &&
                     (status_q == rmq_pkg::ST_OOM || status_q == rmq_pkg::ST_BUF_FULL);
  assign kill      = (d_pkt != 16'd0) && ((d_ret > max_retries) ||
                     ((d_first != '0) &&
                      (limit_q >= $signed({{(LW-TIME_BITS){1'b0}}, d_first}))));
  assign cf_next   = clamp_ns($signed({{2{d_next[NW-1]}}, d_next})
                              - $signed({{(NW-14){1'b0}}, ack_timeout})
                              + $signed({{(NW-14){1'b0}}, retry_timeout}));
  assign tx_next   = clamp_ns($signed({4'b0000, now_q})
                              + $signed({{(NW-14){1'b0}}, ack_timeout}));
  assign first_new = (d_first == '0) ? now_q : d_first;
  assign rd_inc    = rd + CW'(1);
  assign last      = rd_inc == count;
  assign can_enq   = (32'(count) < 32'(capacity)) && (32'(count) < QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rmq_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Next state and table access.
  always_comb begin
    st_next   = st;
    ram_we    = 1'b0;
    ram_waddr = wr[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = rd[AW-1:0];
    unique case (st)
      rmq_pkg::S_IDLE: begin
        if (in_acc) begin
          st_next = rmq_pkg::S_SETUP;
        end
      end
      rmq_pkg::S_SETUP: begin
        if (cmd_q == rmq_pkg::CMD_ENQ) begin
          // Append a fresh entry at the tail.
          ram_we    = can_enq;
          ram_waddr = count[AW-1:0];
          ram_wdata = {pref_q, hin_q | hcnt, {TIME_BITS{1'b0}}, {NW{1'b0}}, 8'd0};
          st_next   = rmq_pkg::S_DONE;
        end else if (cmd_q == rmq_pkg::CMD_TX && blk) begin
          st_next = rmq_pkg::S_DONE;
        end else if (count == '0) begin
          st_next = rmq_pkg::S_FIN;
        end else begin
          st_next = rmq_pkg::S_RD;
        end
      end
      rmq_pkg::S_RD: begin
        st_next = rmq_pkg::S_EV;
      end
      rmq_pkg::S_EV: begin
        st_next = last ? rmq_pkg::S_FIN : rmq_pkg::S_RD;
        if (cmd_q == rmq_pkg::CMD_DROP) begin
          // Compact survivors toward the head.
          ram_we = !kill;
        end else if (found) begin
          // Close the gap left by a removed entry.
          ram_we = 1'b1;
        end else if (cmd_q == rmq_pkg::CMD_CONFIRM && cf_hit) begin
          if (resched) begin
            ram_we    = 1'b1;
            ram_waddr = rd[AW-1:0];
            ram_wdata = {d_pkt, d_hdl, d_first, cf_next, bumped};
            st_next   = rmq_pkg::S_FIN;
          end
        end else if (cmd_q == rmq_pkg::CMD_TX && tx_hit) begin
          if (!tx_remove) begin
            ram_we    = 1'b1;
            ram_waddr = rd[AW-1:0];
            ram_wdata = {d_pkt, d_hdl, first_new, tx_next, bumped};
            st_next   = rmq_pkg::S_FIN;
          end
        end
      end
      rmq_pkg::S_FIN: begin
        st_next = rmq_pkg::S_DONE;
      end
      rmq_pkg::S_DONE: begin
        if (out_ch.ready) begin
          st_next = rmq_pkg::S_IDLE;
        end
      end
      default: st_next = rmq_pkg::S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hcnt  <= '0;
      blk   <= 1'b0;
      found <= 1'b0;
      rd    <= '0;
      wr    <= '0;
    end else begin
      unique case (st)
        rmq_pkg::S_SETUP: begin
          rd    <= '0;
          wr    <= '0;
          found <= 1'b0;
          if (cmd_q == rmq_pkg::CMD_ENQ && can_enq) begin
            count <= count + CW'(1);
            hcnt  <= (hcnt == 16'(HANDLE_MAX)) ? 16'd0 : hcnt + 16'd1;
          end
        end
        rmq_pkg::S_EV: begin
          rd <= rd_inc;
          if (cmd_q == rmq_pkg::CMD_DROP) begin
            if (!kill) begin
              wr <= wr + CW'(1);
            end
          end else if (found) begin
            wr <= wr + CW'(1);
          end else if (cmd_q == rmq_pkg::CMD_CONFIRM && cf_hit) begin
            if (!resched) begin
              found <= 1'b1;
              wr    <= rd;
              blk   <= 1'b0;
            end
          end else if (cmd_q == rmq_pkg::CMD_TX && tx_hit) begin
            blk <= 1'b1;
            if (tx_remove) begin
              found <= 1'b1;
              wr    <= rd;
            end
          end
        end
        rmq_pkg::S_FIN: begin
          if (cmd_q == rmq_pkg::CMD_DROP) begin
            count <= wr;
          end else if (found) begin
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Command latch and result fields.
  always_ff @(posedge clk) begin
    unique case (st)
      rmq_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_q    <= in_ch.cmd;
          now_q    <= in_ch.now;
          pref_q   <= in_ch.packet_ref;
          hin_q    <= in_ch.handle_in;
          status_q <= in_ch.confirm_status;
          prod_q   <= PW'({1'b0, max_retries} + 9'd1) * PW'(ack_timeout);
          res_ok   <= 1'b0;
          res_hout <= '0;
          res_sent <= '0;
          res_rem  <= 1'b0;
          res_drop <= '0;
        end
      end
      rmq_pkg::S_SETUP: begin
        limit_q <= $signed({{(LW-TIME_BITS){1'b0}}, now_q})
                   - $signed({{(LW-PW){1'b0}}, prod_q});
        if (cmd_q == rmq_pkg::CMD_DROP) begin
          res_ok <= 1'b1;
        end else if (cmd_q == rmq_pkg::CMD_ENQ && can_enq) begin
          res_ok   <= 1'b1;
          res_hout <= hin_q | hcnt;
        end
      end
      rmq_pkg::S_EV: begin
        if (cmd_q == rmq_pkg::CMD_DROP) begin
          if (kill) begin
            res_drop <= res_drop + 5'd1;
          end
        end else if (!found && cmd_q == rmq_pkg::CMD_CONFIRM && cf_hit) begin
          res_ok <= 1'b1;
        end else if (!found && cmd_q == rmq_pkg::CMD_TX && tx_hit) begin
          res_ok   <= 1'b1;
          res_hout <= d_hdl;
          res_sent <= d_pkt;
          res_rem  <= tx_remove;
        end
      end
      default: ;
    endcase
  end

  // Ports: the result beat holds in its register until taken.
  assign in_ch.ready               = st == rmq_pkg::S_IDLE;
  assign out_ch.valid              = st == rmq_pkg::S_DONE;
  assign out_ch.ok                 = res_ok;
  assign out_ch.handle_out         = res_hout;
  assign out_ch.sent_packet        = res_sent;
  assign out_ch.removed_after_send = res_rem;
  assign out_ch.dropped_count      = res_drop;
  assign out_ch.occupancy          = 5'(count);
  assign out_ch.blocked            = blk;

  `RMQ_ASSERT_IMP(a_count_bound, 1'b1, 32'(count) <= QUEUE_DEPTH)
  `RMQ_ASSERT_IMP(a_one_side, in_ch.ready, !out_ch.valid)
  `RMQ_ASSERT_IMP(a_compact_order, st == rmq_pkg::S_EV, wr <= rd && rd < count)
  `RMQ_ASSERT_NEXT(a_accept_setup, in_acc, st == rmq_pkg::S_SETUP)
endmodule
`default_nettype wire

FILE: rtl/rmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rmq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/retransmit_message_queue_unit_tb.sv
// Testbench for the retransmit message queue unit: predicted results versus the block.
`default_nettype none
module retransmit_message_queue_unit_tb;

  localparam int NDEPTH = 16;
  localparam longint NEXT_HI = (64'sd1 <<< 33) - 1;
  localparam longint NEXT_LO = -NEXT_HI - 1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [15:0] packet_ref;
    logic [15:0] handle_in;
    logic [1:0]  confirm_status;
  } cmd_beat_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] handle_out;
    logic [15:0] sent_packet;
    logic        removed_after_send;
    logic [4:0]  dropped_count;
    logic [4:0]  occupancy;
    logic        blocked;
  } result_beat_t;

  typedef struct packed {
    logic [15:0] pkt;
    logic [15:0] hnd;
    logic [31:0] first_send;
    logic signed [33:0] next_send;
    logic [7:0]  retries;
  } slot_t;

  logic clk;
  logic rst = 1;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();
  rmq_cfg_if cfg ();

  retransmit_message_queue_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // Shadow of the queue table and registers.
  slot_t       table_q [NDEPTH];
  int          slot_count;
  logic [15:0] next_handle;
  logic        is_blocked;
  logic [4:0]  m_capacity;
  logic [15:0] m_ack_to, m_retry_to;
  logic [7:0]  m_max_retries;

  cmd_beat_t    pending_cmds[$];
  result_beat_t expected_results[$];
  logic [7:0]   pending_cfg_idx[$];
  logic [15:0]  pending_cfg_data[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int sent_seen = 0;
  int dropped_seen = 0;
  int refused_seen = 0;

  // Recent handles and common times drive confirms that hit.
  logic [31:0] clock_now;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_next(longint v);
    if (v > NEXT_HI) return NEXT_HI;
    if (v < NEXT_LO) return NEXT_LO;
    return v;
  endfunction

  function automatic logic [7:0] sat_bump(logic [7:0] r);
    return (r == 8'hFF) ? r : r + 8'd1;
  endfunction

  task automatic remove_slot(int i);
    for (int k = i; k + 1 < slot_count; k++) table_q[k] = table_q[k + 1];
    slot_count--;
  endtask

  function automatic cmd_beat_t in_ch_beat();
    return {in_ch.cmd, in_ch.now, in_ch.packet_ref, in_ch.handle_in, in_ch.confirm_status};
  endfunction

  // Predict the result of one accepted command beat.
  task automatic predict_queue_step(cmd_beat_t c);
    result_beat_t r;
    longint limit;
    longint ns;
    int w;
    logic kill;
    r = '0;
    case (c.cmd)
      rmq_pkg::CMD_ENQ: begin
        if (slot_count < m_capacity && slot_count < NDEPTH) begin
          table_q[slot_count] = '{pkt: c.packet_ref, hnd: c.handle_in | next_handle,
                                  first_send: 32'd0, next_send: 34'sd0, retries: 8'd0};
          r.ok = 1;
          r.handle_out = c.handle_in | next_handle;
          slot_count++;
          next_handle = (next_handle == 16'(rmq_pkg::HANDLE_MAX_DEF)) ? 16'd0
                                                                     : next_handle + 16'd1;
        end
      end
      rmq_pkg::CMD_CONFIRM: begin
        for (int i = 0; i < slot_count; i++) begin
          if (table_q[i].hnd != c.handle_in) continue;
          r.ok = 1;
          if (table_q[i].pkt != 0 && (c.confirm_status == rmq_pkg::ST_OOM ||
                                      c.confirm_status == rmq_pkg::ST_BUF_FULL)) begin
            ns = longint'($signed(table_q[i].next_send)) - longint'(m_ack_to)
                 + longint'(m_retry_to);
            table_q[i].next_send = 34'(clamp_next(ns));
            table_q[i].retries = sat_bump(table_q[i].retries);
          end else begin
            remove_slot(i);
            is_blocked = 0;
          end
          break;
        end
      end
      rmq_pkg::CMD_TX: begin
        if (!is_blocked) begin
          for (int i = 0; i < slot_count; i++) begin
            if (table_q[i].pkt == 0 ||
                longint'($signed(table_q[i].next_send)) > longint'(c.now))
              continue;
            table_q[i].retries = sat_bump(table_q[i].retries);
            table_q[i].next_send = 34'(clamp_next(longint'(c.now) + longint'(m_ack_to)));
            if (table_q[i].first_send == 0) table_q[i].first_send = c.now;
            r.ok = 1;
            r.handle_out = table_q[i].hnd;
            r.sent_packet = table_q[i].pkt;
            is_blocked = 1;
            if (table_q[i].retries >= m_max_retries) begin
              remove_slot(i);
              r.removed_after_send = 1;
            end
            break;
          end
        end
      end
      default: begin
        limit = longint'(c.now) - (longint'(m_max_retries) + 1) * longint'(m_ack_to);
        w = 0;
        for (int i = 0; i < slot_count; i++) begin
          kill = table_q[i].pkt != 0 && (table_q[i].retries > m_max_retries ||
                 (table_q[i].first_send != 0 && limit >= longint'(table_q[i].first_send)));
          if (kill) r.dropped_count++;
          else begin
            table_q[w] = table_q[i];
            w++;
          end
        end
        slot_count = w;
        r.ok = 1;
      end
    endcase
    r.occupancy = slot_count[4:0];
    r.blocked = is_blocked;
    expected_results.insert(expected_results.size(), r);
  endtask

  // Command driver: hold the beat until accepted, advance from the queue.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid) predict_queue_step(in_ch_beat());
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          {in_ch.cmd, in_ch.now, in_ch.packet_ref, in_ch.handle_in, in_ch.confirm_status}
            <= pending_cmds.pop_front();
          in_ch.valid <= 1;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // Configuration driver.
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 0;
    end else begin
      if (!cfg.valid || cfg.ready) begin
        if (cfg.valid) begin
          case (cfg.index)
            rmq_pkg::REG_CAPACITY: m_capacity = cfg.data[4:0];
            rmq_pkg::REG_ACK_TO:   m_ack_to = cfg.data;
            rmq_pkg::REG_RETRY_TO: m_retry_to = cfg.data;
            rmq_pkg::REG_MAX_RETR: m_max_retries = cfg.data[7:0];
            default: ;
          endcase
        end
        if (pending_cfg_idx.size() > 0) begin
          cfg.index <= pending_cfg_idx.pop_front();
          cfg.data <= pending_cfg_data.pop_front();
          cfg.valid <= 1;
        end else begin
          cfg.valid <= 0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest expectation.
  always @(posedge clk) begin
    result_beat_t got, exp_r;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.ok, out_ch.handle_out, out_ch.sent_packet, out_ch.removed_after_send,
               out_ch.dropped_count, out_ch.occupancy, out_ch.blocked};
        results_seen++;
        if (got.sent_packet != 0) sent_seen++;
        dropped_seen += got.dropped_count;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp ok=%0d h=%h pkt=%h rm=%0d drp=%0d occ=%0d blk=%0d",
                exp_r.ok, exp_r.handle_out, exp_r.sent_packet, exp_r.removed_after_send,
                exp_r.dropped_count, exp_r.occupancy, exp_r.blocked);
              $display("          got ok=%0d h=%h pkt=%h rm=%0d drp=%0d occ=%0d blk=%0d",
                got.ok, got.handle_out, got.sent_packet, got.removed_after_send,
                got.dropped_count, got.occupancy, got.blocked);
            end
          end
          if (!exp_r.ok) refused_seen++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_cmd(logic [1:0] cmd, logic [31:0] now, logic [15:0] pref,
                          logic [15:0] hin, logic [1:0] st);
    cmd_beat_t b;
    b = '{cmd, now, pref, hin, st};
    pending_cmds.insert(pending_cmds.size(), b);
  endtask

  task automatic push_cfg(logic [7:0] idx, logic [15:0] data);
    pending_cfg_idx.insert(pending_cfg_idx.size(), idx);
    pending_cfg_data.insert(pending_cfg_data.size(), data);
  endtask

  // Wait until every queued beat is accepted and answered, then let the block settle.
  task automatic drain();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_results.size() > 0 ||
           pending_cfg_idx.size() > 0 || cfg.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed enqueue / transmit / confirm flows.
  task automatic random_phase(int n);
    int pick;
    logic [15:0] h;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(3);
      if (pick < 30) begin
        push_cmd(rmq_pkg::CMD_ENQ, clock_now,
                 ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0, 2'($urandom));
      end else if (pick < 60) begin
        push_cmd(rmq_pkg::CMD_TX, clock_now, 16'($urandom), 16'($urandom), 2'($urandom));
      end else if (pick < 88) begin
        // Confirm a handle most likely held: enqueue handles are counter-based.
        h = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(k % 64));
        push_cmd(rmq_pkg::CMD_CONFIRM, clock_now, 16'($urandom), h, 2'($urandom));
      end else begin
        push_cmd(rmq_pkg::CMD_DROP, clock_now, 16'($urandom), 16'($urandom), 2'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.cmd = 0; in_ch.now = 0; in_ch.packet_ref = 0;
    in_ch.handle_in = 0; in_ch.confirm_status = 0;
    out_ch.ready = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    slot_count = 0; next_handle = 0; is_blocked = 0;
    m_capacity = rmq_pkg::CAPACITY_RST; m_ack_to = rmq_pkg::ACK_TO_RST;
    m_retry_to = rmq_pkg::RETRY_TO_RST; m_max_retries = rmq_pkg::MAX_RETR_RST;
    clock_now = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: fill past capacity, send at time zero, busy and odd confirms, ageing.
    for (int i = 0; i < 17; i++)
      push_cmd(rmq_pkg::CMD_ENQ, 32'd0, (i == 3) ? 16'd0 : 16'hFFFF - i[15:0],
               (i == 0) ? 16'hFFFF : 16'd0, 2'd0);
    push_cmd(rmq_pkg::CMD_TX, 32'd0, 16'd0, 16'd0, 2'd0);
    push_cmd(rmq_pkg::CMD_TX, 32'd0, 16'd0, 16'd0, 2'd0);
    push_cmd(rmq_pkg::CMD_CONFIRM, 32'd0, 16'd0, 16'h1234, 2'd0);
    push_cmd(rmq_pkg::CMD_CONFIRM, 32'd0, 16'd0, 16'hFFFF, rmq_pkg::ST_OOM);
    push_cmd(rmq_pkg::CMD_CONFIRM, 32'd0, 16'd0, 16'hFFFF, 2'd3);
    push_cmd(rmq_pkg::CMD_CONFIRM, 32'd0, 16'd0, 16'd3, 2'd0);
    push_cmd(rmq_pkg::CMD_TX, 32'hFFFF_FFFF, 16'd0, 16'd0, 2'd0);
    push_cmd(rmq_pkg::CMD_CONFIRM, 32'd0, 16'd0, 16'd1, rmq_pkg::ST_BUF_FULL);
    push_cmd(rmq_pkg::CMD_DROP, 32'd0, 16'd0, 16'd0, 2'd0);
    push_cmd(rmq_pkg::CMD_DROP, 32'hFFFF_FFFF, 16'd0, 16'd0, 2'd0);
    drain();

    // Phases: register settings crossed with idling modes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      case (ph)
        0: begin
          push_cfg(rmq_pkg::REG_CAPACITY, 16'd0);
          push_cfg(rmq_pkg::REG_MAX_RETR, 16'd255);
        end
        1: begin
          push_cfg(rmq_pkg::REG_CAPACITY, 16'd16);
          push_cfg(rmq_pkg::REG_ACK_TO, 16'hFFFF);
          push_cfg(rmq_pkg::REG_RETRY_TO, 16'd0);
          push_cfg(rmq_pkg::REG_MAX_RETR, 16'd0);
        end
        2: begin
          push_cfg(rmq_pkg::REG_CAPACITY, 16'd5);
          push_cfg(rmq_pkg::REG_ACK_TO, 16'd0);
          push_cfg(rmq_pkg::REG_RETRY_TO, 16'hFFFF);
          push_cfg(rmq_pkg::REG_MAX_RETR, 16'd1);
        end
        default: begin
          push_cfg(rmq_pkg::REG_CAPACITY, 16'($urandom_range(16)));
          push_cfg(rmq_pkg::REG_ACK_TO,
                   ($urandom_range(1)) ? 16'($urandom_range(8)) : 16'($urandom));
          push_cfg(rmq_pkg::REG_RETRY_TO, 16'($urandom_range(6)));
          push_cfg(rmq_pkg::REG_MAX_RETR, 16'($urandom_range(6)));
        end
      endcase
      drain();
      random_phase(225);
      drain();
    end

    $display("Covered %0d result beats: %0d packets sent, %0d entries aged out or dropped.",
             results_seen, sent_seen, dropped_seen);
    $display("%0d commands were refused or found nothing to act on.", refused_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: slowest run is far below this.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
